[hdl/cau_pkg.sv]
// Package for the complex arithmetic unit: word types, operation and status
// codes, widths and saturation helpers. Depends on nothing.
package cau_pkg;

	localparam int W  = 16;          // operand and result width
	localparam int F  = 8;           // fractional bits
	localparam int PW = 2 * W + 1;   // width of a sum of two products
	localparam int NW = PW + F;      // dividend magnitude width
	localparam int DW = 2 * W;       // |B|^2 width
	localparam int SW = DW + W;      // width of the aligned divisor

	typedef enum logic [1:0] {
		ACT_ADD = 2'd0,
		ACT_SUB = 2'd1,
		ACT_MUL = 2'd2,
		ACT_DIV = 2'd3
	} cau_action_t;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_SAT = 2'd1,
		ST_DZ  = 2'd2
	} cau_status_t;

	typedef struct packed {
		logic [1:0]          action;
		logic signed [W-1:0] a_re;
		logic signed [W-1:0] a_im;
		logic signed [W-1:0] b_re;
		logic signed [W-1:0] b_im;
	} cau_in_t;

	typedef struct packed {
		logic signed [W-1:0] res_re;
		logic signed [W-1:0] res_im;
		logic [1:0]          status;
	} cau_res_t;

	typedef struct packed {
		logic signed [W-1:0] v;
		logic                f;
	} cau_sat_t;

	// Word travelling through the divider steps
	typedef struct packed {
		logic                is_div;
		logic                dz;
		logic signed [W-1:0] re;
		logic signed [W-1:0] im;
		logic                sat;
		logic                neg_re;
		logic                neg_im;
		logic                ovf_re;
		logic                ovf_im;
		logic [NW-1:0]       rem_re;
		logic [NW-1:0]       rem_im;
		logic [W-1:0]        q_re;
		logic [W-1:0]        q_im;
		logic [DW-1:0]       den;
	} cau_div_t;

	localparam logic signed [PW-1:0] SMAX = PW'((64'sd1 <<< (W - 1)) - 64'sd1);
	localparam logic signed [PW-1:0] SMIN = -SMAX - PW'(1);

	// Clamp a wide signed value to the W-bit range
	function automatic cau_sat_t sat_pw(input logic signed [PW-1:0] x);
		cau_sat_t r;
		r.f = 1'b0;
		r.v = x[W-1:0];
		if (x > SMAX) begin
			r.v = SMAX[W-1:0];
			r.f = 1'b1;
		end else if (x < SMIN) begin
			r.v = SMIN[W-1:0];
			r.f = 1'b1;
		end
		return r;
	endfunction

	// Sign and clamp a divider quotient
	function automatic cau_sat_t div_fin(input logic neg, input logic ovf,
			input logic [W-1:0] q);
		cau_sat_t r;
		r.f = 1'b0;
		if (neg) begin
			if (ovf || (q[W-1] && (|q[W-2:0]))) begin
				r.v = SMIN[W-1:0];
				r.f = 1'b1;
			end else begin
				r.v = -$signed(q);
			end
		end else begin
			if (ovf || q[W-1]) begin
				r.v = SMAX[W-1:0];
				r.f = 1'b1;
			end else begin
				r.v = $signed(q);
			end
		end
		return r;
	endfunction

endpackage

[hdl/cau_divider.sv]
// Pipelined restoring divider: one quotient bit per stage for both parts.
// Depends on cau_pkg.
module cau_divider
	import cau_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  cau_div_t in_word,
	output logic     out_valid,
	output cau_div_t out_word
);

	logic     vld_s [0:W];
	cau_div_t stg_s [0:W];

	assign vld_s[0] = in_valid;
	assign stg_s[0] = in_word;

	for (genvar i = 0; i < W; i++) begin : g_step
		localparam int B = W - 1 - i;
		cau_div_t nxt;
		logic [SW-1:0] sh;
		logic [SW-1:0] rre;
		logic [SW-1:0] rim;

		always_comb begin
			nxt = stg_s[i];
			sh  = SW'(stg_s[i].den) << B;
			rre = SW'(stg_s[i].rem_re);
			rim = SW'(stg_s[i].rem_im);
			if (rre >= sh) begin
				nxt.rem_re  = NW'(rre - sh);
				nxt.q_re[B] = 1'b1;
			end
			if (rim >= sh) begin
				nxt.rem_im  = NW'(rim - sh);
				nxt.q_im[B] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			stg_s[i+1] <= nxt;
		end
	end

	assign out_valid = vld_s[W];
	assign out_word  = stg_s[W];

endmodule

[hdl/complex_arithmetic_unit.sv]
// Top level of the complex arithmetic unit: operand stage, product sums,
// divider setup and result register. Depends on cau_pkg and cau_divider.
//
// Usage:
//   Drive cmd with an operation and two complex Q8.8 operands and raise
//   start. The word is taken at any rising edge where start is high and
//   busy is low; busy stays low, so one word may enter every cycle.
//   The result word appears on result for exactly one cycle with done high.
//   Every operation takes the same path: one product stage, one sum stage,
//   one divider setup stage, W restoring divider steps (one quotient bit
//   each) and the output register. Add, subtract and multiply ride the
//   same pipeline so results leave in order.
//   Throughput is one word per cycle, held by the six operand multipliers
//   and the per-bit divider stages each working on a different word.
//   Division gives A*conj(B)/|B|^2 truncated toward zero; a zero divisor
//   gives a zero result and divide-by-zero status. Results saturate to the
//   16-bit range and report it in status.
//   Reset clears all valid bits; words in flight are dropped. The receiver
//   cannot hold results off, so nothing in the pipeline ever stalls.
module complex_arithmetic_unit
	import cau_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  cau_in_t  cmd,
	output logic     done,
	output cau_res_t result
);

	// The pipeline never stalls
	assign busy = 1'b0;

	logic take;
	assign take = start && !busy;

	// Stage 1: products and add/subtract
	logic                   v_s1;
	logic [1:0]             act_s1;
	logic signed [DW-1:0]   p_rr_s1, p_ii_s1, p_ir_s1, p_ri_s1, p_bb_s1, p_jj_s1;
	cau_sat_t               as_re_s1, as_im_s1;

	logic signed [W:0]      add_re, add_im;
	always_comb begin
		if (cmd.action == ACT_SUB) begin
			add_re = (W+1)'(cmd.a_re) - (W+1)'(cmd.b_re);
			add_im = (W+1)'(cmd.a_im) - (W+1)'(cmd.b_im);
		end else begin
			add_re = (W+1)'(cmd.a_re) + (W+1)'(cmd.b_re);
			add_im = (W+1)'(cmd.a_im) + (W+1)'(cmd.b_im);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		act_s1   <= cmd.action;
		p_rr_s1  <= cmd.a_re * cmd.b_re;
		p_ii_s1  <= cmd.a_im * cmd.b_im;
		p_ir_s1  <= cmd.a_im * cmd.b_re;
		p_ri_s1  <= cmd.a_re * cmd.b_im;
		p_bb_s1  <= cmd.b_re * cmd.b_re;
		p_jj_s1  <= cmd.b_im * cmd.b_im;
		as_re_s1 <= sat_pw(PW'(add_re));
		as_im_s1 <= sat_pw(PW'(add_im));
	end

	// Stage 2: combine products; multiply takes re = rr - ii, div re = rr + ii
	logic                 v_s2;
	logic [1:0]           act_s2;
	logic signed [PW-1:0] sre_s2, sim_s2;
	logic [DW-1:0]        den_s2;
	cau_sat_t             as_re_s2, as_im_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		act_s2   <= act_s1;
		as_re_s2 <= as_re_s1;
		as_im_s2 <= as_im_s1;
		den_s2   <= $unsigned(p_bb_s1) + $unsigned(p_jj_s1);
		if (act_s1 == ACT_MUL) begin
			sre_s2 <= PW'(p_rr_s1) - PW'(p_ii_s1);
			sim_s2 <= PW'(p_ir_s1) + PW'(p_ri_s1);
		end else begin
			sre_s2 <= PW'(p_rr_s1) + PW'(p_ii_s1);
			sim_s2 <= PW'(p_ir_s1) - PW'(p_ri_s1);
		end
	end

	// Stage 3: multiply rescale, dividend magnitude and quotient overflow check
	logic     v_s3;
	cau_div_t d_s3;
	cau_div_t d_nxt;

	logic [PW-1:0] mag_re, mag_im;
	logic [NW-1:0] num_re, num_im;
	logic [SW-1:0] lim;
	cau_sat_t      m_re, m_im;

	always_comb begin
		mag_re = sre_s2[PW-1] ? PW'(-sre_s2) : PW'(sre_s2);
		mag_im = sim_s2[PW-1] ? PW'(-sim_s2) : PW'(sim_s2);
		num_re = NW'(mag_re) << F;
		num_im = NW'(mag_im) << F;
		lim    = SW'(den_s2) << W;
		m_re   = sat_pw(sre_s2 >>> F);
		m_im   = sat_pw(sim_s2 >>> F);

		d_nxt        = '0;
		d_nxt.is_div = (act_s2 == ACT_DIV);
		d_nxt.dz     = (den_s2 == '0);
		d_nxt.neg_re = sre_s2[PW-1];
		d_nxt.neg_im = sim_s2[PW-1];
		d_nxt.ovf_re = SW'(num_re) >= lim;
		d_nxt.ovf_im = SW'(num_im) >= lim;
		d_nxt.rem_re = num_re;
		d_nxt.rem_im = num_im;
		d_nxt.den    = den_s2;
		if (act_s2 == ACT_MUL) begin
			d_nxt.re  = m_re.v;
			d_nxt.im  = m_im.v;
			d_nxt.sat = m_re.f | m_im.f;
		end else begin
			d_nxt.re  = as_re_s2.v;
			d_nxt.im  = as_im_s2.v;
			d_nxt.sat = as_re_s2.f | as_im_s2.f;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		d_s3 <= d_nxt;
	end

	// Divider steps; non-divide words ride along unchanged in their result fields
	logic     dv_valid;
	cau_div_t dv_word;

	cau_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.in_word   (d_s3),
		.out_valid (dv_valid),
		.out_word  (dv_word)
	);

	// Output register: sign and clamp quotients, pick the status
	cau_res_t res_nxt;
	cau_sat_t q_re, q_im;

	always_comb begin
		q_re = div_fin(dv_word.neg_re, dv_word.ovf_re, dv_word.q_re);
		q_im = div_fin(dv_word.neg_im, dv_word.ovf_im, dv_word.q_im);
		if (dv_word.is_div) begin
			if (dv_word.dz) begin
				res_nxt.res_re = '0;
				res_nxt.res_im = '0;
				res_nxt.status = ST_DZ;
			end else begin
				res_nxt.res_re = q_re.v;
				res_nxt.res_im = q_im.v;
				res_nxt.status = (q_re.f | q_im.f) ? ST_SAT : ST_OK;
			end
		end else begin
			res_nxt.res_re = dv_word.re;
			res_nxt.res_im = dv_word.im;
			res_nxt.status = dv_word.sat ? ST_SAT : ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		result <= res_nxt;
	end

endmodule

[dv/cau_checker.sv]
// Checker for the complex arithmetic unit: watches the command and result
// channels, predicts each result word and compares it. Depends on cau_pkg.
module cau_checker
	import cau_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     busy,
	input  cau_in_t  cmd,
	input  logic     done,
	input  cau_res_t result,
	output int       fail_count,
	output int       pending,
	output int       accepted_words,
	output int       result_words
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint VMAX = (64'sd1 <<< (W - 1)) - 1;
	localparam longint VMIN = -(64'sd1 <<< (W - 1));

	cau_res_t expected_words[$];

	function automatic longint clamp(input longint v, inout bit flag);
		if (v > VMAX) begin
			flag = 1'b1;
			return VMAX;
		end
		if (v < VMIN) begin
			flag = 1'b1;
			return VMIN;
		end
		return v;
	endfunction

	// Quotient of num * 2^F by den, truncated toward zero, clamped
	function automatic longint quot_trunc(input longint num, input longint den,
			inout bit flag);
		longint mag;
		longint q;
		bit neg;
		neg = num < 0;
		mag = neg ? -num : num;
		// |num| < 2^33, so the shifted magnitude fits easily in 64 bits
		q = (mag <<< F) / den;
		return clamp(neg ? -q : q, flag);
	endfunction

	function automatic cau_res_t compute_result(input cau_in_t c);
		cau_res_t r;
		longint ar, ai, br, bi, re, im, den;
		bit flag;
		ar = c.a_re; ai = c.a_im; br = c.b_re; bi = c.b_im;
		re = 0; im = 0; flag = 1'b0;
		r.status = ST_OK;
		case (cau_action_t'(c.action))
			ACT_ADD: begin
				re = clamp(ar + br, flag);
				im = clamp(ai + bi, flag);
			end
			ACT_SUB: begin
				re = clamp(ar - br, flag);
				im = clamp(ai - bi, flag);
			end
			ACT_MUL: begin
				// arithmetic shift rounds toward minus infinity
				re = clamp((ar * br - ai * bi) >>> F, flag);
				im = clamp((ai * br + ar * bi) >>> F, flag);
			end
			default: begin
				den = br * br + bi * bi;
				if (den == 0) begin
					r.status = ST_DZ;
				end else begin
					re = quot_trunc(ar * br + ai * bi, den, flag);
					im = quot_trunc(ai * br - ar * bi, den, flag);
				end
			end
		endcase
		if (flag)
			r.status = ST_SAT;
		r.res_re = re[W-1:0];
		r.res_im = im[W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cau_res_t exp_w;
		int errs;
		errs = 0;
		if (!arst_n) begin
			fail_count     <= 0;
			accepted_words <= 0;
			result_words   <= 0;
			expected_words.delete();
		end else begin
			if (done) begin
				result_words <= result_words + 1;
				if (expected_words.size() == 0) begin
					$error("result word with nothing expected: %h", result);
					errs++;
				end else begin
					exp_w = expected_words.pop_front();
					if (result.res_re !== exp_w.res_re) begin
						$error("res_re expected %0d actual %0d", exp_w.res_re, result.res_re);
						errs++;
					end
					if (result.res_im !== exp_w.res_im) begin
						$error("res_im expected %0d actual %0d", exp_w.res_im, result.res_im);
						errs++;
					end
					if (result.status !== exp_w.status) begin
						$error("status expected %0d actual %0d", exp_w.status, result.status);
						errs++;
					end
				end
			end
			if (errs != 0)
				fail_count <= fail_count + errs;
			if (start && !busy) begin
				expected_words.push_back(compute_result(cmd));
				accepted_words <= accepted_words + 1;
			end
		end
	end

	assign pending = expected_words.size();

endmodule

[dv/complex_arithmetic_unit_tb.sv]
// Testbench top for the complex arithmetic unit: clock, reset, command
// stimulus and verdict. Depends on cau_pkg, cau_checker and the block.
module complex_arithmetic_unit_tb;
	import cau_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_WORDS = 900;
	localparam int LATENCY      = W + 4;
	localparam int STALL_LIMIT  = 2000;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	cau_in_t  cmd;
	logic     done;
	cau_res_t result;
	int       fail_count;
	int       pending;
	int       accepted_words;
	int       result_words;
	int       idle_cycles;

	complex_arithmetic_unit i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.cmd   (cmd),
		.done  (done),
		.result(result)
	);

	cau_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.cmd           (cmd),
		.done          (done),
		.result        (result),
		.fail_count    (fail_count),
		.pending       (pending),
		.accepted_words(accepted_words),
		.result_words  (result_words)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Watchdog: count cycles where no word moves on either side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((start && !busy) || done) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", STALL_LIMIT);
				$display("FAIL complex_arithmetic_unit");
				$finish;
			end
		end
	end

	// Pick an operand part: random half the time, else an extreme or a small value
	function automatic logic [W-1:0] pick_part();
		case ($urandom_range(0, 9))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return W'($urandom_range(0, 1023)) - W'(512);
			4: return 16'hffff;
			default: return W'($urandom);
		endcase
	endfunction

	// Present one word and hold it until the block takes it
	task automatic send_word(input cau_action_t act, input logic [W-1:0] ar,
			input logic [W-1:0] ai, input logic [W-1:0] br, input logic [W-1:0] bi);
		cmd   <= '{action: act, a_re: ar, a_im: ai, b_re: br, b_im: bi};
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic idle_burst();
		start <= 1'b0;
		cmd   <= {2'($urandom), 64'({$urandom, $urandom})};
		repeat ($urandom_range(1, 6))
			@(negedge clk);
	endtask

	initial begin
		cau_action_t act;
		logic [W-1:0] br;
		logic [W-1:0] bi;
		int n;
		arst_n = 1'b0;
		start  = 1'b0;
		cmd    = '0;
		repeat (2)
			@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed words: extremes, every operation, saturation, zero divisor
		send_word(ACT_ADD, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
		send_word(ACT_ADD, 16'h0100, 16'hff00, 16'h0080, 16'h0040);
		send_word(ACT_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
		send_word(ACT_SUB, 16'h0000, 16'h0000, 16'h8000, 16'h0001);
		send_word(ACT_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_word(ACT_MUL, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000);
		send_word(ACT_MUL, 16'h0100, 16'h0000, 16'hfff1, 16'h0003);
		send_word(ACT_MUL, 16'hffff, 16'h0001, 16'h0001, 16'hffff);
		idle_burst();
		send_word(ACT_DIV, 16'h0100, 16'h0200, 16'h0000, 16'h0000);
		send_word(ACT_DIV, 16'h7fff, 16'h8000, 16'h0000, 16'h0000);
		send_word(ACT_DIV, 16'h7fff, 16'h7fff, 16'h0001, 16'h0000);
		send_word(ACT_DIV, 16'h8000, 16'h8000, 16'h0000, 16'hffff);
		send_word(ACT_DIV, 16'h0100, 16'h0000, 16'h0300, 16'h0000);
		send_word(ACT_DIV, 16'hff00, 16'h0000, 16'h0300, 16'h0000);
		send_word(ACT_DIV, 16'h8000, 16'h0000, 16'h8000, 16'h8000);
		send_word(ACT_DIV, 16'h0000, 16'h8000, 16'h0100, 16'h0000);
		send_word(ACT_DIV, 16'h8000, 16'h0000, 16'hff00, 16'h0000);
		send_word(ACT_DIV, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);

		// Random words; bursts of idling only before the final stretch
		for (n = 0; n < RANDOM_WORDS; n++) begin
			act = cau_action_t'($urandom_range(0, 3));
			br  = pick_part();
			bi  = pick_part();
			if (act == ACT_DIV && $urandom_range(0, 15) == 0) begin
				br = '0;
				bi = '0;
			end
			send_word(act, pick_part(), pick_part(), br, bi);
			if (n < RANDOM_WORDS - 150 && $urandom_range(0, 5) == 0)
				idle_burst();
		end
		start <= 1'b0;

		// Drain: wait for outstanding results, then let the pipe settle
		while (pending != 0)
			@(negedge clk);
		repeat (LATENCY + 4)
			@(negedge clk);

		$display("covered %0d command words over add, subtract, multiply and divide",
			accepted_words);
		$display("checked %0d result words, saturation and zero-divisor cases included",
			result_words);
		if (fail_count == 0) begin
			$display("PASS complex_arithmetic_unit");
		end else begin
			$display("FAIL complex_arithmetic_unit");
		end
		$finish;
	end

endmodule

[sim.f]
hdl/cau_pkg.sv
hdl/cau_divider.sv
hdl/complex_arithmetic_unit.sv
dv/cau_checker.sv
dv/complex_arithmetic_unit_tb.sv
